// File: sv/smb_pkg.sv
// Shared types and constants of the stereo mix bus.
// No dependencies; every other file of the block but smb_cfg_if imports this package.
package smb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TRIM_W   = 8;
  localparam int PAN_W    = 8;
  localparam int SUM_W    = 24;
  localparam int FACTOR_W = TRIM_W + 1;
  localparam int PROD_W   = SAMPLE_W + FACTOR_W;

  localparam logic [TRIM_W-1:0] TRIM_MUTE  = 8'h00;
  localparam logic [TRIM_W-1:0] TRIM_UNITY = 8'hff;

  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;
  localparam logic signed [SUM_W-1:0]    SUM_MAX = 24'sh7fffff;
  localparam logic signed [SUM_W-1:0]    SUM_MIN = 24'sh800000;

  localparam logic STEREO_RESET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAN,
    ST_PAN,
    ST_ACC,
    ST_EMIT
  } smb_state_t;

  // Controller to datapath: at most one step of the datapath per cycle.
  typedef struct packed {
    logic load;       // take the input item, apply group trim
    logic chan_step;  // apply channel trim
    logic pan_step;   // compute the far-side pan product
    logic acc_step;   // add into the running sums
    logic emit;       // saturate sums into the output register, clear sums
  } smb_cmd_t;

  typedef struct packed {
    logic last;       // the item at work ends the frame
  } smb_sts_t;

endpackage

// File: sv/smb_in_if.sv
// Input channel of the mix bus: one channel contribution per transfer.
// Depends on smb_pkg for field widths.
interface smb_in_if;
  import smb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] voice_sample;
  logic        [TRIM_W-1:0]   group_trim;
  logic        [TRIM_W-1:0]   channel_trim;
  logic signed [PAN_W-1:0]    pan_position;
  logic                       last_of_frame;

  modport source (output valid, voice_sample, group_trim, channel_trim, pan_position,
                  last_of_frame, input ready);
  modport sink   (input valid, voice_sample, group_trim, channel_trim, pan_position,
                  last_of_frame, output ready);
endinterface

// File: sv/smb_out_if.sv
// Output channel of the mix bus: one saturated stereo frame per transfer.
// Depends on smb_pkg for field widths.
interface smb_out_if;
  import smb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       left_clipped;
  logic                       right_clipped;

  modport source (output valid, left_out, right_out, left_clipped, right_clipped,
                  input ready);
  modport sink   (input valid, left_out, right_out, left_clipped, right_clipped,
                  output ready);
endinterface

// File: sv/smb_cfg_if.sv
// Configuration write channel of the mix bus: carries the stereo mode bit.
// No dependencies.
interface smb_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: sv/stereo_mix_bus_pan_clip.sv
// Top level of the stereo mix bus with pan and clip.
// Depends on smb_pkg, smb_in_if, smb_out_if, smb_cfg_if, smb_ctrl and smb_dp.
//
//   port     | direction | carries
//   ---------+-----------+----------------------------------------------------
//   mix_in   | sink      | one channel contribution: sample, trims, pan, last
//   mix_out  | source    | one saturated frame: left, right, clip flags
//   cfg      | sink      | stereo mode bit, always ready
//
// Items are taken one at a time: the accept cycle applies the group trim, then
// the channel trim and the pan product follow on the single shared 16x9
// multiplier, then the accumulate. The item that ends a frame then loads the
// output register in a frame step, held while a prior frame waits there.
// Reset sets stereo mode and clears both sums; no clearing pass is needed.
// A stalled output only holds the frame step; items keep flowing otherwise.
module stereo_mix_bus_pan_clip (
  input  logic      clk,
  input  logic      rst,
  smb_in_if.sink    mix_in,
  smb_out_if.source mix_out,
  smb_cfg_if.sink   cfg
);
  import smb_pkg::*;

  smb_cmd_t cmd;
  smb_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // The mode register takes a write on any cycle.
  assign cfg.ready = 1'b1;

  assign mix_in.ready  = in_ready;
  assign mix_out.valid = out_valid;

  // Sequence the four steps of an item and the frame transfer.
  smb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_in.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (mix_out.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Trim, pan, accumulate with saturation, clip to 16 bits on frame end.
  smb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.data[0]),
    .voice_sample  (mix_in.voice_sample),
    .group_trim    (mix_in.group_trim),
    .channel_trim  (mix_in.channel_trim),
    .pan_position  (mix_in.pan_position),
    .last_of_frame (mix_in.last_of_frame),
    .left_out      (mix_out.left_out),
    .right_out     (mix_out.right_out),
    .left_clipped  (mix_out.left_clipped),
    .right_clipped (mix_out.right_clipped)
  );

endmodule

// File: sv/smb_ctrl.sv
// Sequencer of the mix bus: steps one item through the shared multiplier.
// Depends on smb_pkg for the state enum and the command/status structs.
module smb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output smb_pkg::smb_cmd_t cmd,
  input  smb_pkg::smb_sts_t sts
);
  import smb_pkg::*;

  smb_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHAN;
        end
      end
      ST_CHAN: begin
        cmd.chan_step = 1'b1;
        state_next    = ST_PAN;
      end
      ST_PAN: begin
        cmd.pan_step = 1'b1;
        state_next   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        state_next   = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CHAN))
    else $error("accepted item did not start the channel step");

  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted frame not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("frame emitted over a waiting result");
`endif

endmodule

// File: sv/smb_dp.sv
// Datapath of the mix bus: shared multiplier, running sums, output register.
// Depends on smb_pkg for widths, limits and the command/status structs.
module smb_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  smb_pkg::smb_cmd_t                   cmd,
  output smb_pkg::smb_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic                                cfg_data,
  input  logic signed [smb_pkg::SAMPLE_W-1:0] voice_sample,
  input  logic        [smb_pkg::TRIM_W-1:0]   group_trim,
  input  logic        [smb_pkg::TRIM_W-1:0]   channel_trim,
  input  logic signed [smb_pkg::PAN_W-1:0]    pan_position,
  input  logic                                last_of_frame,
  output logic signed [smb_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [smb_pkg::SAMPLE_W-1:0] right_out,
  output logic                                left_clipped,
  output logic                                right_clipped
);
  import smb_pkg::*;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]    acc,
    input logic signed [SAMPLE_W-1:0] v
  );
    logic signed [SUM_W:0] t;
    begin
      t = {acc[SUM_W-1], acc} + {{(SUM_W-SAMPLE_W+1){v[SAMPLE_W-1]}}, v};
      if (t[SUM_W] != t[SUM_W-1]) begin
        sat_add = t[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        sat_add = t[SUM_W-1:0];
      end
    end
  endfunction

  function automatic logic clip_hit(input logic signed [SUM_W-1:0] v);
    begin
      clip_hit = !((&v[SUM_W-1:SAMPLE_W-1]) || !(|v[SUM_W-1:SAMPLE_W-1]));
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip16(input logic signed [SUM_W-1:0] v);
    begin
      if (clip_hit(v)) begin
        clip16 = v[SUM_W-1] ? OUT_MIN : OUT_MAX;
      end else begin
        clip16 = v[SAMPLE_W-1:0];
      end
    end
  endfunction

  logic                       stereo_mode;
  logic signed [SAMPLE_W-1:0] samp;
  logic signed [SAMPLE_W-1:0] far;
  logic        [TRIM_W-1:0]   ctrim;
  logic signed [PAN_W-1:0]    pan;
  logic                       last;
  logic signed [SUM_W-1:0]    left_sum;
  logic signed [SUM_W-1:0]    right_sum;

  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [FACTOR_W-1:0] mul_b;
  logic signed [FACTOR_W-1:0] pan_factor;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] prod_sh8;
  logic signed [SAMPLE_W-1:0] prod_sh7;
  logic signed [SAMPLE_W-1:0] left_add;
  logic signed [SAMPLE_W-1:0] right_add;

  // Far-side factor: 128+pan left of centre, 127-pan right of centre.
  always_comb begin
    if (pan[PAN_W-1]) begin
      pan_factor = {pan[PAN_W-1], pan} + FACTOR_W'(128);
    end else begin
      pan_factor = FACTOR_W'(127) - {pan[PAN_W-1], pan};
    end
  end

  // One shared multiplier: group trim on load, then channel trim, then pan.
  always_comb begin
    mul_a = cmd.load ? voice_sample : samp;
    if (cmd.load) begin
      mul_b = {1'b0, group_trim};
    end else if (cmd.chan_step) begin
      mul_b = {1'b0, ctrim};
    end else begin
      mul_b = pan_factor;
    end
    prod     = mul_a * mul_b;
    prod_sh8 = prod[SAMPLE_W+7:8];
    prod_sh7 = prod[SAMPLE_W+6:7];
  end

  always_comb begin
    left_add  = samp;
    right_add = samp;
    if (!stereo_mode) begin
      right_add = '0;
    end else if (pan[PAN_W-1]) begin
      right_add = far;
    end else if (pan != '0) begin
      left_add = far;
    end
  end

  assign sts.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= STEREO_RESET;
    end else if (cfg_we) begin
      stereo_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ctrim <= channel_trim;
      pan   <= pan_position;
      last  <= last_of_frame;
      if (group_trim == TRIM_MUTE) begin
        samp <= '0;
      end else if (group_trim == TRIM_UNITY) begin
        samp <= voice_sample;
      end else begin
        samp <= prod_sh8;
      end
    end else if (cmd.chan_step) begin
      samp <= prod_sh8;
    end
    if (cmd.pan_step) begin
      far <= prod_sh7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= '0;
      right_sum <= '0;
    end else if (cmd.emit) begin
      left_sum  <= '0;
      right_sum <= '0;
    end else if (cmd.acc_step) begin
      left_sum <= sat_add(left_sum, left_add);
      if (stereo_mode) begin
        right_sum <= sat_add(right_sum, right_add);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      left_out     <= clip16(left_sum);
      left_clipped <= clip_hit(left_sum);
      if (stereo_mode) begin
        right_out     <= clip16(right_sum);
        right_clipped <= clip_hit(right_sum);
      end else begin
        right_out     <= '0;
        right_clipped <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (left_sum == '0 && right_sum == '0))
    else $error("sums not cleared after frame");

  a_mono_right_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc_step && !stereo_mode) |=> $stable(right_sum))
    else $error("right sum moved in mono mode");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (!left_clipped || left_out == OUT_MAX || left_out == OUT_MIN))
    else $error("left clip flag without a saturated value");
`endif

endmodule
